>>> rtl/sha256_pkg.sv
// Shared constants, types and bit functions of the SHA-256 hasher.
package sha256_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned NumRounds = 64;
	localparam int unsigned NumWords  = 16;
	localparam int unsigned NumHash   = 8;
	localparam logic [7:0]  PadByte   = 8'h80;
	localparam logic [5:0]  LenPos    = 6'd56;
	localparam logic [63:0] BitsPerByte = 64'd8;

	localparam word_t K_TABLE [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t IV_TABLE [NumHash] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Rotate right by a constant amount.
	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

>>> rtl/sha256_message_hasher_core.sv
// SHA-256 byte-stream hasher: block buffer, round sequencer and digest output.
//
// Usage:
//   Input channel (data_valid / data_stall) carries one transaction per message
//   byte: data_byte is taken when byte_present is high; end_of_message closes
//   the message after that byte. A transaction with neither bit set does nothing.
//   Output channel (digest_valid / digest_stall) returns eight transactions per
//   message: digest_word with word_index 0..7, most significant word first,
//   last_word high on the eighth.
// Sequence:
//   A byte that does not complete a block is stored in the buffer. A byte that
//   completes a 64-byte block starts one shared round unit, which runs 64 rounds,
//   one per cycle; a fold step then adds the result into the chaining value.
//   Closing a message runs the padded block (two padded blocks when 56 or more
//   bytes are pending), then returns the eight digest words.
//   data_stall is high whenever the sequencer is not idle.
// Reset and stall:
//   arst_n clears the fill count, bit length and sequencer and loads the initial
//   hash values. A stalled output holds its word; the sequencer waits. After the
//   last word the block reinitializes for the next message.
module sha256_message_hasher_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 data_valid,
	output logic                 data_stall,
	input  logic [7:0]           data_byte,
	input  logic                 byte_present,
	input  logic                 end_of_message,
	output logic                 digest_valid,
	input  logic                 digest_stall,
	output sha256_pkg::word_t    digest_word,
	output logic [2:0]           word_index,
	output logic                 last_word
);
	import sha256_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_ROUND = 3'd2;
	localparam logic [2:0] S_FOLD  = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        pend_q;
	logic        extra_q;
	logic        final_q;
	word_t       h_q [NumHash];
	word_t       v_q [NumHash];
	word_t       w_q [NumWords];

	logic        take;
	word_t       t1;
	word_t       t2;
	word_t       ch;
	word_t       maj;
	word_t       w_new;
	word_t       pad_w [NumWords];
	logic        pad_final;

	assign take = data_valid && !data_stall;
	assign data_stall = (state_q != S_IDLE);

	// Drive the output transaction from the chaining value
	assign digest_valid = (state_q == S_OUT);
	assign digest_word  = h_q[idx_q];
	assign word_index   = idx_q;
	assign last_word    = (idx_q == 3'd7);

	// Compute one round and the next schedule word
	always_comb begin
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big_sigma1(v_q[4]) + ch + K_TABLE[rnd_q] + w_q[0];
		t2    = big_sigma0(v_q[0]) + maj;
		w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	// Build the padded block from the pending bytes
	always_comb begin
		logic [5:0] p;
		logic       with_len;
		with_len  = extra_q || (fill_q < LenPos);
		pad_final = with_len;
		for (int j = 0; j < NumWords; j++) begin
			for (int b = 0; b < 4; b++) begin
				p = 6'(j * 4 + b);
				if (!extra_q && p < fill_q) begin
					pad_w[j][8*(3-b) +: 8] = w_q[j][8*(3-b) +: 8];
				end else if (!extra_q && p == fill_q) begin
					pad_w[j][8*(3-b) +: 8] = PadByte;
				end else begin
					pad_w[j][8*(3-b) +: 8] = 8'h00;
				end
			end
		end
		if (with_len) begin
			pad_w[14] = bits_q[63:32];
			pad_w[15] = bits_q[31:0];
		end
	end

	// Sequence buffering, rounds, padding and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			extra_q <= 1'b0;
			final_q <= 1'b0;
			for (int i = 0; i < NumHash; i++) h_q[i] <= IV_TABLE[i];
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						pend_q <= end_of_message;
						rnd_q  <= '0;
						if (byte_present) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + BitsPerByte;
						end
						if (byte_present && fill_q == 6'd63) begin
							final_q <= 1'b0;
							state_q <= S_ROUND;
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					final_q <= pad_final;
					extra_q <= !pad_final;
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= S_FOLD;
				end
				S_FOLD: begin
					for (int i = 0; i < NumHash; i++) h_q[i] <= h_q[i] + v_q[i];
					fill_q <= '0;
					idx_q  <= '0;
					if (pend_q && final_q) state_q <= S_OUT;
					else if (pend_q) state_q <= S_PAD;
					else state_q <= S_IDLE;
				end
				S_OUT: begin
					if (!digest_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= S_IDLE;
							fill_q  <= '0;
							bits_q  <= '0;
							pend_q  <= 1'b0;
							extra_q <= 1'b0;
							final_q <= 1'b0;
							for (int i = 0; i < NumHash; i++) h_q[i] <= IV_TABLE[i];
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold working variables and schedule window
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && take && byte_present) begin
			case (fill_q[1:0])
				2'd0: w_q[fill_q[5:2]][31:24] <= data_byte;
				2'd1: w_q[fill_q[5:2]][23:16] <= data_byte;
				2'd2: w_q[fill_q[5:2]][15:8]  <= data_byte;
				default: w_q[fill_q[5:2]][7:0] <= data_byte;
			endcase
		end else if (state_q == S_PAD) begin
			for (int j = 0; j < NumWords; j++) w_q[j] <= pad_w[j];
		end else if (state_q == S_ROUND) begin
			for (int j = 0; j < NumWords - 1; j++) w_q[j] <= w_q[j+1];
			w_q[NumWords-1] <= w_new;
		end
		if (state_q == S_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			for (int i = 0; i < NumHash; i++) v_q[i] <= h_q[i];
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> state_q == S_OUT)
		else $error("digest transaction outside output phase");
	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == 6'd63) |=> state_q == S_FOLD)
		else $error("round loop did not end after 64 rounds");
	a_pad_then_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PAD |=> (state_q == S_ROUND && rnd_q == 6'd0))
		else $error("padding not followed by round 0");
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && last_word) |=>
		(state_q == S_IDLE && fill_q == 6'd0 && bits_q == 64'd0))
		else $error("state not cleared after last digest word");

endmodule
